### src/wrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wrl_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  localparam logic [2:0] DEPTH_MAX = 3'd4;
  localparam logic [10:0] TOTAL_MAX = 11'd2047;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic [2:0] depth_in;
  } item_t;

  typedef struct packed {
    logic        lake_found;
    logic [10:0] best_total;
    logic        in_best_lake;
    logic [2:0]  cell_depth;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_QUERY,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_RD,
    ST_POP,
    ST_NB_RD,
    ST_NB_CHK,
    ST_REGION_END,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

### src/weighted_region_labeler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Labels 4-connected water regions of a GRID_SIZE x GRID_SIZE depth grid held in on-chip
// RAM and keeps the region with the largest depth sum. The RAM is addressed by row and
// column, each side padded to the next power of two, so it holds W words where W is that
// padded side squared (256 for GRID_SIZE 16). A load or query is accepted with start high
// and busy low, and the next command can be accepted once the query state has answered.
// A solve first clears the label RAM. It then scans every word with a read and a check step
// and works through each water cell (a pop, then one read and one check per neighbor),
// ends each region in a region-end step, then reports. After reset the depth and label
// RAMs are cleared one word a cycle, with busy high. Every command gives one result
// on result_o, marked by done_o for one cycle; the receiver cannot stall.
module weighted_region_labeler_top #(
  parameter int GRID_SIZE = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire wrl_pkg::item_t   item_i,
  output logic                  done_o,
  output wrl_pkg::result_t      result_o
);

  localparam int Gw = $clog2(GRID_SIZE);
  localparam int Pitch = 1 << Gw;
  localparam int Cells = Pitch * Pitch;
  localparam int Aw = 2 * Gw;
  localparam int Lw = Aw + 1;
  localparam int Sw = Aw + 1;
  localparam logic [Aw:0] CellsW = Aw'(0) + (Aw+1)'(Cells);
  localparam logic [Gw:0] Gmax = (Gw+1)'(GRID_SIZE - 1);

  wrl_pkg::state_e state_q, state_d;
  wrl_pkg::item_t  item_q, item_d;
  logic [Aw:0]  cnt_q, cnt_d;
  logic [Aw-1:0] idx_q, idx_d;
  logic [1:0]   dir_q, dir_d;
  logic [Aw-1:0] nb_q, nb_d;
  logic [Sw-1:0] sp_q, sp_d;
  logic [Lw-1:0] label_q, label_d, best_label_q, best_label_d;
  logic [10:0]  run_q, run_d, best_q, best_d;
  logic         solved_q, solved_d;
  logic         done_q, done_d;
  wrl_pkg::result_t res_q, res_d;

  logic          dg_we, lb_we, st_we;
  logic [Aw-1:0] dg_wa, dg_ra, lb_wa, lb_ra, st_wa, st_ra;
  logic [2:0]    dg_wd, dg_rd;
  logic [Lw-1:0] lb_wd, lb_rd;
  logic [Aw-1:0] st_wd, st_rd;

  wrl_ram #(.Width(3), .Depth(Cells)) u_depth (
    .clk_i, .we_i(dg_we), .waddr_i(dg_wa), .wdata_i(dg_wd), .raddr_i(dg_ra), .rdata_o(dg_rd));
  wrl_ram #(.Width(Lw), .Depth(Cells)) u_label (
    .clk_i, .we_i(lb_we), .waddr_i(lb_wa), .wdata_i(lb_wd), .raddr_i(lb_ra), .rdata_o(lb_rd));
  wrl_ram #(.Width(Aw), .Depth(Cells)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd));

  logic          in_grid;
  logic [Aw-1:0] in_idx;
  logic [Aw-1:0] req_idx;
  logic [Gw:0]   r_pos, c_pos;
  logic          nb_ok;
  logic [Aw-1:0] nb_idx;
  logic [11:0]   sum;
  logic          fresh;

  assign in_grid = ({1'b0, item_q.cell_row} <= 5'(Gmax)) && ({1'b0, item_q.cell_col} <= 5'(Gmax));
  assign in_idx  = {Gw'(item_q.cell_row), Gw'(item_q.cell_col)};
  assign req_idx = {Gw'(item_i.cell_row), Gw'(item_i.cell_col)};
  assign r_pos   = {1'b0, idx_q[Aw-1:Gw]};
  assign c_pos   = {1'b0, idx_q[Gw-1:0]};
  assign fresh   = (dg_rd != 3'd0) && (lb_rd != label_q);
  assign sum     = {1'b0, run_q} + {9'd0, dg_rd};

  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = idx_q;
    case (dir_q)
      2'd0: begin
        nb_ok = r_pos != '0;
        nb_idx = idx_q - Aw'(Pitch);
      end
      2'd1: begin
        nb_ok = c_pos != Gmax;
        nb_idx = idx_q + Aw'(1);
      end
      2'd2: begin
        nb_ok = r_pos != Gmax;
        nb_idx = idx_q + Aw'(Pitch);
      end
      default: begin
        nb_ok = c_pos != '0;
        nb_idx = idx_q - Aw'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wrl_pkg::ST_CLEAR;
      cnt_q        <= '0;
      sp_q         <= '0;
      label_q      <= '0;
      best_label_q <= '0;
      run_q        <= '0;
      best_q       <= '0;
      solved_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      sp_q         <= sp_d;
      label_q      <= label_d;
      best_label_q <= best_label_d;
      run_q        <= run_d;
      best_q       <= best_d;
      solved_q     <= solved_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    dir_q  <= dir_d;
    nb_q   <= nb_d;
    res_q  <= res_d;
  end

  // Labels restart at one each solve but the label store keeps old values, so a
  // solve first rewrites every label to zero in the clear sweep.
  always_comb begin
    state_d = state_q;
    item_d = item_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    dir_d = dir_q;
    nb_d = nb_q;
    sp_d = sp_q;
    label_d = label_q;
    best_label_d = best_label_q;
    run_d = run_q;
    best_d = best_q;
    solved_d = solved_q;
    done_d = 1'b0;
    res_d = res_q;
    dg_we = 1'b0;
    dg_wa = cnt_q[Aw-1:0];
    dg_wd = 3'd0;
    dg_ra = in_idx;
    lb_we = 1'b0;
    lb_wa = cnt_q[Aw-1:0];
    lb_wd = '0;
    lb_ra = in_idx;
    st_we = 1'b0;
    st_wa = sp_q[Aw-1:0];
    st_wd = idx_q;
    st_ra = sp_q[Aw-1:0] - Aw'(1);
    case (state_q)
      wrl_pkg::ST_CLEAR: begin
        dg_we = 1'b1;
        lb_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CellsW - 1'b1) begin
          cnt_d = '0;
          state_d = (item_q.command == wrl_pkg::CMD_SOLVE && solved_q == 1'b0 && label_q == '1)
                    ? wrl_pkg::ST_SCAN_RD : wrl_pkg::ST_IDLE;
        end
        dg_we = (label_q != '1);
        if (label_q == '1) begin
          state_d = (cnt_q == CellsW - 1'b1) ? wrl_pkg::ST_SCAN_RD : wrl_pkg::ST_CLEAR;
        end
      end
      wrl_pkg::ST_IDLE: begin
        dg_ra = req_idx;
        lb_ra = req_idx;
        if (start) begin
          item_d = item_i;
          state_d = wrl_pkg::ST_QUERY;
          if (wrl_pkg::cmd_e'(item_i.command) == wrl_pkg::CMD_SOLVE) begin
            label_d = '1;
            cnt_d = '0;
            state_d = wrl_pkg::ST_CLEAR;
          end
        end
      end
      wrl_pkg::ST_QUERY: begin
        res_d = '0;
        if (item_q.command == wrl_pkg::CMD_LOAD && in_grid) begin
          dg_we = 1'b1;
          dg_wa = in_idx;
          dg_wd = (item_q.depth_in > wrl_pkg::DEPTH_MAX) ? wrl_pkg::DEPTH_MAX : item_q.depth_in;
          solved_d = 1'b0;
        end
        if (item_q.command == wrl_pkg::CMD_QUERY && in_grid) begin
          res_d.cell_depth = dg_rd;
          res_d.in_best_lake = solved_q && (best_label_q != '0) && (lb_rd == best_label_q);
        end
        res_d.lake_found = (item_q.command == wrl_pkg::CMD_LOAD && in_grid) ? 1'b0 :
                           (solved_q && best_q != '0);
        res_d.best_total = (item_q.command == wrl_pkg::CMD_LOAD && in_grid) ? '0 :
                           (solved_q ? best_q : '0);
        done_d = 1'b1;
        state_d = wrl_pkg::ST_IDLE;
      end
      wrl_pkg::ST_SCAN_RD: begin
        if (cnt_q == CellsW) begin
          solved_d = 1'b1;
          run_d = '0;
          sp_d = '0;
          state_d = wrl_pkg::ST_DONE;
        end else begin
          dg_ra = cnt_q[Aw-1:0];
          lb_ra = cnt_q[Aw-1:0];
          label_d = (cnt_q == '0) ? '0 : label_q;
          state_d = wrl_pkg::ST_SCAN_CHK;
        end
      end
      wrl_pkg::ST_SCAN_CHK: begin
        if (dg_rd != 3'd0 && lb_rd == '0) begin
          label_d = label_q + 1'b1;
          lb_we = 1'b1;
          lb_wa = cnt_q[Aw-1:0];
          lb_wd = label_q + 1'b1;
          run_d = {8'd0, dg_rd};
          st_we = 1'b1;
          st_wa = '0;
          st_wd = cnt_q[Aw-1:0];
          sp_d = Sw'(1);
          state_d = wrl_pkg::ST_POP_RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
          state_d = wrl_pkg::ST_SCAN_RD;
        end
      end
      wrl_pkg::ST_POP_RD: begin
        if (sp_q == '0) begin
          state_d = wrl_pkg::ST_REGION_END;
        end else begin
          st_ra = sp_q[Aw-1:0] - Aw'(1);
          sp_d = sp_q - 1'b1;
          state_d = wrl_pkg::ST_POP;
        end
      end
      wrl_pkg::ST_POP: begin
        idx_d = st_rd;
        dir_d = 2'd0;
        state_d = wrl_pkg::ST_NB_RD;
      end
      wrl_pkg::ST_NB_RD: begin
        if (nb_ok) begin
          dg_ra = nb_idx;
          lb_ra = nb_idx;
          nb_d = nb_idx;
          state_d = wrl_pkg::ST_NB_CHK;
        end else begin
          dir_d = dir_q + 2'd1;
          state_d = (dir_q == 2'd3) ? wrl_pkg::ST_POP_RD : wrl_pkg::ST_NB_RD;
        end
      end
      wrl_pkg::ST_NB_CHK: begin
        if (fresh) begin
          lb_we = 1'b1;
          lb_wa = nb_q;
          lb_wd = label_q;
          run_d = sum[11] ? wrl_pkg::TOTAL_MAX : sum[10:0];
          if (sp_q < (Sw)'(CellsW)) begin
            st_we = 1'b1;
            st_wd = nb_q;
            sp_d = sp_q + 1'b1;
          end
        end
        dir_d = dir_q + 2'd1;
        state_d = (dir_q == 2'd3) ? wrl_pkg::ST_POP_RD : wrl_pkg::ST_NB_RD;
      end
      wrl_pkg::ST_REGION_END: begin
        if (run_q > best_q) begin
          best_d = run_q;
          best_label_d = label_q;
        end
        cnt_d = cnt_q + 1'b1;
        state_d = wrl_pkg::ST_SCAN_RD;
      end
      wrl_pkg::ST_DONE: begin
        res_d = '0;
        res_d.lake_found = best_q != '0;
        res_d.best_total = best_q;
        done_d = 1'b1;
        state_d = wrl_pkg::ST_IDLE;
      end
      default: state_d = wrl_pkg::ST_IDLE;
    endcase
    if (state_q == wrl_pkg::ST_IDLE && start &&
        wrl_pkg::cmd_e'(item_i.command) == wrl_pkg::CMD_SOLVE) begin
      best_d = '0;
      best_label_d = '0;
      solved_d = 1'b0;
    end
  end

  assign busy     = (state_q != wrl_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == wrl_pkg::ST_IDLE) else $error("result outside idle");
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= Sw'(CellsW)) else $error("stack overflow");
  a_best_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_q != '0) |-> (best_label_q != '0)) else $error("best sum without label");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command not processed");
`endif

endmodule
`default_nettype wire

### src/wrl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module wrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### verif/tb_weighted_region_labeler_top.sv
`timescale 1ns / 1ps
module tb_weighted_region_labeler_top;

  localparam int GRID = 16;
  localparam int CELLS = GRID * GRID;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  wrl_pkg::item_t item_i;
  logic done_o;
  wrl_pkg::result_t result_o;

  weighted_region_labeler_top #(.GRID_SIZE(GRID)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  logic [2:0] depth_map [CELLS];
  int unsigned lake_id [CELLS];
  int unsigned best_id;
  int unsigned best_sum;
  bit solved;
  wrl_pkg::result_t pending_q[$];
  int errors;
  int transfers;
  int results_seen;
  int solves_sent;
  bit no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void solve_grid();
    int unsigned stk[$];
    int unsigned lbl;
    int unsigned run;
    int unsigned cur;
    int unsigned nb[4];
    int n;
    lbl = 0;
    best_id = 0;
    best_sum = 0;
    for (int i = 0; i < CELLS; i++) lake_id[i] = 0;
    for (int s = 0; s < CELLS; s++) begin
      if (depth_map[s] == 0 || lake_id[s] != 0) continue;
      lbl++;
      run = depth_map[s];
      lake_id[s] = lbl;
      stk.push_back(s);
      while (stk.size() > 0) begin
        cur = stk.pop_back();
        n = 0;
        if (cur / GRID > 0) begin nb[n] = cur - GRID; n++; end
        if (cur % GRID + 1 < GRID) begin nb[n] = cur + 1; n++; end
        if (cur / GRID + 1 < GRID) begin nb[n] = cur + GRID; n++; end
        if (cur % GRID > 0) begin nb[n] = cur - 1; n++; end
        for (int k = 0; k < n; k++) begin
          if (depth_map[nb[k]] != 0 && lake_id[nb[k]] == 0) begin
            lake_id[nb[k]] = lbl;
            run = run + depth_map[nb[k]];
            if (run > wrl_pkg::TOTAL_MAX) run = wrl_pkg::TOTAL_MAX;
            stk.push_back(nb[k]);
          end
        end
      end
      if (run > best_sum) begin
        best_sum = run;
        best_id = lbl;
      end
    end
    solved = 1'b1;
  endfunction

  function automatic wrl_pkg::result_t predict_answer(wrl_pkg::item_t it);
    wrl_pkg::result_t r;
    int unsigned idx;
    bit on_grid;
    r = '0;
    on_grid = it.cell_row < GRID && it.cell_col < GRID;
    idx = it.cell_row * GRID + it.cell_col;
    case (wrl_pkg::cmd_e'(it.command))
      wrl_pkg::CMD_LOAD: begin
        if (on_grid) begin
          depth_map[idx] = (it.depth_in > wrl_pkg::DEPTH_MAX) ? wrl_pkg::DEPTH_MAX : it.depth_in;
          solved = 1'b0;
        end
      end
      wrl_pkg::CMD_SOLVE: solve_grid();
      wrl_pkg::CMD_QUERY: begin
        if (on_grid) begin
          r.cell_depth = depth_map[idx];
          r.in_best_lake = solved && best_id != 0 && lake_id[idx] == best_id;
        end
      end
      default: ;
    endcase
    r.lake_found = solved && best_sum > 0;
    r.best_total = solved ? 11'(best_sum) : 11'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        wrl_pkg::result_t w;
        w = pending_q.pop_front();
        if (result_o.lake_found !== w.lake_found)
          report_mismatch("lake_found", result_o.lake_found, w.lake_found);
        if (result_o.best_total !== w.best_total)
          report_mismatch("best_total", result_o.best_total, w.best_total);
        if (result_o.in_best_lake !== w.in_best_lake)
          report_mismatch("in_best_lake", result_o.in_best_lake, w.in_best_lake);
        if (result_o.cell_depth !== w.cell_depth)
          report_mismatch("cell_depth", result_o.cell_depth, w.cell_depth);
      end
    end
  end

  task automatic send_command(wrl_pkg::cmd_e c, int r, int col, int d);
    wrl_pkg::item_t it;
    it.command = c;
    it.cell_row = 4'(r);
    it.cell_col = 4'(col);
    it.depth_in = 3'(d);
    if (!no_gaps) begin
      while ($urandom_range(99) < 36) begin
        start <= 1'b0;
        item_i <= wrl_pkg::item_t'(13'($urandom));
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(predict_answer(it));
    transfers++;
    if (c == wrl_pkg::CMD_SOLVE) solves_sent++;
  endtask

  task automatic test_directed();
    send_command(wrl_pkg::CMD_QUERY, 0, 0, 7);
    send_command(wrl_pkg::CMD_SOLVE, 0, 0, 0);
    send_command(wrl_pkg::CMD_LOAD, 0, 0, 7);
    send_command(wrl_pkg::CMD_LOAD, 15, 15, 3);
    send_command(wrl_pkg::CMD_LOAD, 0, 1, 4);
    send_command(wrl_pkg::CMD_LOAD, 5, 5, 2);
    send_command(wrl_pkg::CMD_LOAD, 5, 6, 5);
    send_command(wrl_pkg::CMD_QUERY, 0, 0, 0);
    send_command(wrl_pkg::CMD_NOP, 15, 15, 7);
    send_command(wrl_pkg::CMD_SOLVE, 0, 0, 0);
    send_command(wrl_pkg::CMD_QUERY, 0, 1, 0);
    send_command(wrl_pkg::CMD_QUERY, 5, 5, 0);
    send_command(wrl_pkg::CMD_QUERY, 15, 15, 0);
    send_command(wrl_pkg::CMD_NOP, 0, 0, 0);
    send_command(wrl_pkg::CMD_QUERY, 0, 0, 0);
    send_command(wrl_pkg::CMD_LOAD, 15, 14, 1);
    send_command(wrl_pkg::CMD_QUERY, 15, 15, 0);
    send_command(wrl_pkg::CMD_LOAD, 0, 1, 0);
    send_command(wrl_pkg::CMD_SOLVE, 0, 0, 0);
    send_command(wrl_pkg::CMD_QUERY, 5, 6, 0);
    send_command(wrl_pkg::CMD_QUERY, 0, 0, 0);
  endtask

  task automatic test_full_flood();
    for (int r = 0; r < GRID; r++)
      for (int c = 0; c < GRID; c++) send_command(wrl_pkg::CMD_LOAD, r, c, 4 + (r + c) % 4);
    send_command(wrl_pkg::CMD_SOLVE, 0, 0, 0);
    send_command(wrl_pkg::CMD_QUERY, 7, 9, 0);
    send_command(wrl_pkg::CMD_LOAD, 3, 3, 0);
    send_command(wrl_pkg::CMD_QUERY, 7, 9, 0);
  endtask

  task automatic test_random_maps();
    int lands;
    wrl_pkg::cmd_e c;
    while (transfers < 1250) begin
      no_gaps = (transfers > 700 && transfers < 850);
      lands = $urandom_range(50, 10);
      for (int i = 0; i < lands; i++)
        send_command(wrl_pkg::CMD_LOAD, $urandom_range(15), $urandom_range(15),
                     $urandom_range(7));
      send_command(wrl_pkg::CMD_SOLVE, $urandom_range(15), $urandom_range(15),
                   $urandom_range(7));
      for (int i = 0; i < 12; i++) begin
        c = wrl_pkg::cmd_e'($urandom_range(99) < 85 ? wrl_pkg::CMD_QUERY : $urandom_range(3));
        send_command(c, $urandom_range(15), $urandom_range(15), $urandom_range(7));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    errors = 0;
    transfers = 0;
    results_seen = 0;
    solves_sent = 0;
    no_gaps = 1'b0;
    solved = 1'b0;
    best_id = 0;
    best_sum = 0;
    for (int i = 0; i < CELLS; i++) begin
      depth_map[i] = '0;
      lake_id[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_flood();
    test_random_maps();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d commands, %0d solves, %0d results checked",
             transfers, solves_sent, results_seen);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
